@@ hdl/cosine_similarity_clamped_defines.svh @@
`ifndef COSINE_SIMILARITY_CLAMPED_DEFINES_SVH
`define COSINE_SIMILARITY_CLAMPED_DEFINES_SVH

// condition holds at every edge out of reset
`define CSC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/csc_pkg.sv @@
`timescale 1ns / 1ps

package csc_pkg;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned ROOT_W = 24;
  localparam int unsigned SIM_W  = 17;
  localparam int unsigned CNT_W  = 6;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  localparam logic [SIM_W-1:0] ONE_Q16 = 17'd65536;

  // first trial bit of the root: highest even power of two below 2^47
  localparam logic [ACC_W-1:0] SQRT_BIT_INIT = 48'h4000_0000_0000;

  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd23;
  // 47 dot bits followed by 16 zero bits
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd62;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_MUL_AB,
    ST_ACC_AB,
    ST_CHECK,
    ST_SQRT_A,
    ST_SQRT_B,
    ST_MUL_R,
    ST_DIV,
    ST_FIN
  } csc_state_e;

endpackage

@@ hdl/csc_if.sv @@
`timescale 1ns / 1ps

interface csc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic               last_element;

  modport source (output valid, output elem_a, output elem_b, output last_element,
                  input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last_element,
                  output ready);
endinterface

interface csc_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] similarity;
  logic        zero_magnitude;

  modport source (output valid, output similarity, output zero_magnitude, input ready);
  modport sink   (input valid, input similarity, input zero_magnitude, output ready);
endinterface

@@ hdl/cosine_similarity_clamped.sv @@
// Clamped cosine similarity of two streamed Q4.12 vectors.
// Input channel (in_if): one element pair per item, last_element marks the
// final pair. Output channel (out_if): one item per vector, similarity in
// unsigned Q1.16 (65536 = 1.0) and zero_magnitude when either energy is 0.
// One 25x25 multiplier, one 48-bit restoring square-root step and one
// 49-bit restoring divide step are reused under a small sequencer.
// Input pairs: a pair is accepted only in idle and finished before the next
// (accept, then a*a, b*b, a*b through the shared multiplier and the last accumulate).
// After the last pair: a check state, then either straight to the output
// stage, or 24 + 24 root iterations, 1 multiply and 63 divide steps.
// The output register decouples the sides: new pairs are accepted while a
// result waits; a finished result stalls in place until the register frees.
// Reset clears the sums, the sequencer and the output valid.
`timescale 1ns / 1ps
`include "cosine_similarity_clamped_defines.svh"

module cosine_similarity_clamped (
  input  logic      clk_i,
  input  logic      rst_ni,
  csc_in_if.sink    in_if,
  csc_out_if.source out_if
);
  import csc_pkg::*;

  csc_state_e state_q, state_d;

  logic signed [ELEM_W-1:0] a_q, a_d, b_q, b_d;
  logic                     last_q, last_d;

  logic signed [ACC_W-1:0]  dot_sum_q, dot_sum_d;
  logic signed [ACC_W-1:0]  first_energy_q, first_energy_d;
  logic signed [ACC_W-1:0]  second_energy_q, second_energy_d;

  logic signed [ACC_W:0]    prod_q, prod_d;
  logic signed [24:0]       mul_x, mul_y;
  logic signed [49:0]       mul_p;

  logic [ACC_W-1:0]         v_q, v_d, root_q, root_d, bit_q, bit_d;
  logic [ACC_W-1:0]         sq_trial, v_n, root_n;
  logic [ROOT_W-1:0]        ra_q, ra_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic [ACC_W-1:0]         rem_q, rem_d;
  logic [ACC_W:0]           rem_sh;
  logic                     div_ge;
  logic [SIM_W-1:0]         quo_q, quo_d;
  logic                     over_q, over_d;
  logic                     zf_q, zf_d;

  logic                     out_valid_q, out_valid_d;
  logic [SIM_W-1:0]         sim_q, sim_d;
  logic                     zero_mag_q, zero_mag_d;

  logic                     in_fire, out_load, energy_zero, dot_nonpos;
  logic [SIM_W-1:0]         sim_res;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ACC_W:0]   p
  );
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + p;
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_if.ready);

  assign energy_zero = (first_energy_q == '0) || (second_energy_q == '0);
  assign dot_nonpos  = dot_sum_q[ACC_W-1] || (dot_sum_q == '0);

  // shared multiplier
  always_comb begin
    unique case (state_q)
      ST_MUL_AA: begin
        mul_x = {{9{a_q[ELEM_W-1]}}, a_q};
        mul_y = {{9{a_q[ELEM_W-1]}}, a_q};
      end
      ST_MUL_BB: begin
        mul_x = {{9{b_q[ELEM_W-1]}}, b_q};
        mul_y = {{9{b_q[ELEM_W-1]}}, b_q};
      end
      ST_MUL_AB: begin
        mul_x = {{9{a_q[ELEM_W-1]}}, a_q};
        mul_y = {{9{b_q[ELEM_W-1]}}, b_q};
      end
      default: begin
        mul_x = {1'b0, ra_q};
        mul_y = {1'b0, root_q[ROOT_W-1:0]};
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // shared root step
  always_comb begin
    sq_trial = root_q + bit_q;
    if (v_q >= sq_trial) begin
      v_n    = v_q - sq_trial;
      root_n = (root_q >> 1) + bit_q;
    end else begin
      v_n    = v_q;
      root_n = root_q >> 1;
    end
  end

  // shared divide step, numerator bits come out of the dot register
  assign rem_sh  = {rem_q, dot_sum_q[ACC_W-2]};
  assign div_ge  = rem_sh >= {1'b0, prod_q[ACC_W-1:0]};
  assign sim_res = (over_q || (quo_q > ONE_Q16)) ? ONE_Q16 : quo_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_MUL_AA;
      ST_MUL_AA: state_d = ST_MUL_BB;
      ST_MUL_BB: state_d = ST_MUL_AB;
      ST_MUL_AB: state_d = ST_ACC_AB;
      ST_ACC_AB: state_d = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK:  state_d = (energy_zero || dot_nonpos) ? ST_FIN : ST_SQRT_A;
      ST_SQRT_A: if (cnt_q == SQRT_LAST) state_d = ST_SQRT_B;
      ST_SQRT_B: if (cnt_q == SQRT_LAST) state_d = ST_MUL_R;
      ST_MUL_R:  state_d = ST_DIV;
      ST_DIV:    if (cnt_q == DIV_LAST) state_d = ST_FIN;
      ST_FIN:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    a_d             = a_q;
    b_d             = b_q;
    last_d          = last_q;
    dot_sum_d       = dot_sum_q;
    first_energy_d  = first_energy_q;
    second_energy_d = second_energy_q;
    prod_d          = prod_q;
    v_d             = v_q;
    root_d          = root_q;
    bit_d           = bit_q;
    ra_d            = ra_q;
    cnt_d           = cnt_q;
    rem_d           = rem_q;
    quo_d           = quo_q;
    over_d          = over_q;
    zf_d            = zf_q;
    sim_d           = sim_q;
    zero_mag_d      = zero_mag_q;
    out_valid_d     = out_valid_q && !out_if.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          a_d    = in_if.elem_a;
          b_d    = in_if.elem_b;
          last_d = in_if.last_element;
        end
      end
      ST_MUL_AA: prod_d = mul_p[ACC_W:0];
      ST_MUL_BB: begin
        first_energy_d = sat_add(first_energy_q, prod_q);
        prod_d         = mul_p[ACC_W:0];
      end
      ST_MUL_AB: begin
        second_energy_d = sat_add(second_energy_q, prod_q);
        prod_d          = mul_p[ACC_W:0];
      end
      ST_ACC_AB: dot_sum_d = sat_add(dot_sum_q, prod_q);
      ST_CHECK: begin
        zf_d   = energy_zero;
        quo_d  = '0;
        over_d = 1'b0;
        v_d    = first_energy_q;
        root_d = '0;
        bit_d  = SQRT_BIT_INIT;
        cnt_d  = '0;
      end
      ST_SQRT_A: begin
        v_d    = v_n;
        root_d = root_n;
        bit_d  = bit_q >> 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          ra_d   = root_n[ROOT_W-1:0];
          v_d    = second_energy_q;
          root_d = '0;
          bit_d  = SQRT_BIT_INIT;
          cnt_d  = '0;
        end
      end
      ST_SQRT_B: begin
        v_d    = v_n;
        root_d = root_n;
        bit_d  = bit_q >> 2;
        cnt_d  = cnt_q + 1'b1;
      end
      ST_MUL_R: begin
        prod_d = mul_p[ACC_W:0];
        rem_d  = '0;
        cnt_d  = '0;
      end
      ST_DIV: begin
        rem_d     = div_ge ? ACC_W'(rem_sh - {1'b0, prod_q[ACC_W-1:0]}) : rem_sh[ACC_W-1:0];
        dot_sum_d = dot_sum_q <<< 1;
        quo_d     = {quo_q[SIM_W-2:0], div_ge};
        over_d    = over_q | quo_q[SIM_W-1];
        cnt_d     = cnt_q + 1'b1;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d     = 1'b1;
          sim_d           = sim_res;
          zero_mag_d      = zf_q;
          dot_sum_d       = '0;
          first_energy_d  = '0;
          second_energy_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      out_valid_q     <= 1'b0;
      dot_sum_q       <= '0;
      first_energy_q  <= '0;
      second_energy_q <= '0;
    end else begin
      state_q         <= state_d;
      out_valid_q     <= out_valid_d;
      dot_sum_q       <= dot_sum_d;
      first_energy_q  <= first_energy_d;
      second_energy_q <= second_energy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    last_q     <= last_d;
    prod_q     <= prod_d;
    v_q        <= v_d;
    root_q     <= root_d;
    bit_q      <= bit_d;
    ra_q       <= ra_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    over_q     <= over_d;
    zf_q       <= zf_d;
    sim_q      <= sim_d;
    zero_mag_q <= zero_mag_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.similarity     = sim_q;
  assign out_if.zero_magnitude = zero_mag_q;

  `CSC_ASSERT_ALWAYS(a_energy_nonneg, clk_i, rst_ni,
    !first_energy_q[ACC_W-1] && !second_energy_q[ACC_W-1], "energy went negative")
  `CSC_ASSERT_IMPL(a_sim_range, clk_i, rst_ni, out_if.valid,
    out_if.similarity <= ONE_Q16, "similarity above one")
  `CSC_ASSERT_IMPL(a_zero_mag_sim, clk_i, rst_ni, out_if.valid && out_if.zero_magnitude,
    out_if.similarity == '0, "zero magnitude with nonzero similarity")
  `CSC_ASSERT_NEXT(a_clear_after_out, clk_i, rst_ni, out_load,
    dot_sum_q == '0 && first_energy_q == '0 && second_energy_q == '0 && out_if.valid,
    "sums not cleared after result")

endmodule

@@ dv/cosine_similarity_clamped_test.sv @@
`timescale 1ns / 1ps

module cosine_similarity_clamped_test;
  import csc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 1700;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    logic               calm;
  } pair_item_t;

  typedef struct {
    logic [SIM_W-1:0] similarity;
    logic             zero_magnitude;
  } sim_result_t;

  logic clk_i;
  logic rst_ni;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();

  cosine_similarity_clamped dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pair_item_t  pending_pairs[$];
  sim_result_t sim_expect_q[$];

  longint dot_acc;
  longint a_energy;
  longint b_energy;

  logic        in_fire;
  logic        calm_phase;
  int unsigned errors;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint sat_sum(longint acc, longint prod);
    longint s;
    s = acc + prod;
    if (s > longint'(ACC_MAX)) s = longint'(ACC_MAX);
    if (s < longint'(ACC_MIN)) s = longint'(ACC_MIN);
    return s;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = 23; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // accumulate one pair; on the last pair queue the similarity and clear
  task automatic fold_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    sim_result_t     res;
    longint unsigned den;
    longint unsigned quo;
    dot_acc  = sat_sum(dot_acc, longint'(a) * longint'(b));
    a_energy = sat_sum(a_energy, longint'(a) * longint'(a));
    b_energy = sat_sum(b_energy, longint'(b) * longint'(b));
    if (last) begin
      res.similarity     = '0;
      res.zero_magnitude = 1'b0;
      if (a_energy == 0 || b_energy == 0) begin
        res.zero_magnitude = 1'b1;
      end else if (dot_acc > 0) begin
        den = floor_root(a_energy) * floor_root(b_energy);
        quo = (longint'(dot_acc) << 16) / den;
        if (quo > ONE_Q16) quo = ONE_Q16;
        res.similarity = quo[SIM_W-1:0];
      end
      sim_expect_q.push_back(res);
      dot_acc  = 0;
      a_energy = 0;
      b_energy = 0;
    end
  endtask

  task automatic add_pair(logic signed [15:0] a, logic signed [15:0] b, logic last,
                          logic calm);
    pair_item_t p;
    p.a    = a;
    p.b    = b;
    p.last = last;
    p.calm = calm;
    pending_pairs.push_back(p);
  endtask

  // input side: acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready)
      fold_pair(in_ch.elem_a, in_ch.elem_b, in_ch.last_element);
  end

  always @(negedge clk_i) begin
    pair_item_t p;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_pairs.size() != 0 &&
          (pending_pairs[0].calm || $urandom_range(0, 99) >= 34)) begin
        p = pending_pairs.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.elem_a       <= p.a;
        in_ch.elem_b       <= p.b;
        in_ch.last_element <= p.last;
        calm_phase         <= p.calm;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm_phase || $urandom_range(0, 99) >= 34;
  end

  always @(posedge clk_i) begin
    sim_result_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (sim_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result similarity=%0d zero_magnitude=%0b",
                 $time, out_ch.similarity, out_ch.zero_magnitude);
      end else begin
        exp_res = sim_expect_q.pop_front();
        if (out_ch.similarity !== exp_res.similarity) begin
          errors++;
          $display("%0t: similarity expected %0d actual %0d",
                   $time, exp_res.similarity, out_ch.similarity);
        end
        if (out_ch.zero_magnitude !== exp_res.zero_magnitude) begin
          errors++;
          $display("%0t: zero_magnitude expected %0b actual %0b",
                   $time, exp_res.zero_magnitude, out_ch.zero_magnitude);
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk_i);
    $display("cosine_similarity_clamped verification failed");
    $finish;
  end

  initial begin
    int unsigned n_rand;
    int unsigned len;
    int unsigned kind;
    logic        side;
    logic        calm;
    logic signed [15:0] a;
    logic signed [15:0] b;

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.elem_a       = '0;
    in_ch.elem_b       = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready       = 1'b0;
    in_fire            = 1'b0;
    calm_phase         = 1'b0;
    errors             = 0;
    cycle_count        = 0;
    dot_acc            = 0;
    a_energy           = 0;
    b_energy           = 0;

    // full-scale identical vectors
    add_pair(16'sd32767, 16'sd32767, 1'b1, 1'b0);
    add_pair(-16'sd32768, -16'sd32768, 1'b1, 1'b0);
    // negative dot product
    add_pair(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
    add_pair(16'sd32767, -16'sd32768, 1'b0, 1'b0);
    add_pair(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
    // zero magnitude on either or both sides
    add_pair(16'sd0, 16'sd5, 1'b1, 1'b0);
    add_pair(16'sd5, 16'sd0, 1'b1, 1'b0);
    add_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
    add_pair(16'sd0, 16'sd7, 1'b0, 1'b0);
    add_pair(16'sd0, -16'sd3, 1'b1, 1'b0);
    // zero dot product, nonzero energies
    add_pair(16'sd1, 16'sd0, 1'b0, 1'b0);
    add_pair(16'sd0, 16'sd1, 1'b1, 1'b0);
    // root truncation drives the quotient above one; exact roots give exactly one
    add_pair(16'sd1, 16'sd1, 1'b0, 1'b0);
    add_pair(16'sd1, 16'sd1, 1'b1, 1'b0);
    add_pair(16'sd3, 16'sd3, 1'b1, 1'b0);
    // ordinary mixed vector
    add_pair(16'sd4096, 16'sd2048, 1'b0, 1'b0);
    add_pair(-16'sd1234, 16'sd3000, 1'b0, 1'b0);
    add_pair(16'sd777, -16'sd100, 1'b1, 1'b0);

    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
        6, 7, 8:          len = $urandom_range(5, 16);
        default:          len = $urandom_range(17, 64);
      endcase
      kind = $urandom_range(0, 9);
      side = 1'($urandom_range(0, 1));
      calm = n_rand >= 600 && n_rand < 900;
      for (int unsigned i = 0; i < len; i++) begin
        a = 16'($urandom);
        b = 16'($urandom);
        case (kind)
          3: begin
            a = 16'($urandom_range(0, 31) - 16);
            b = 16'($urandom_range(0, 31) - 16);
          end
          4, 5: b = clip16(int'(a) + int'($urandom_range(0, 64)) - 32);
          6:    b = clip16(-int'(a));
          7: begin
            if (side) a = '0;
            else b = '0;
          end
          8: begin
            if ($urandom_range(0, 1)) a = '0;
            if ($urandom_range(0, 1)) b = '0;
          end
          9:       b = a;
          default: ;
        endcase
        add_pair(a, b, i == len - 1, calm);
      end
      n_rand += len;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_pairs.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (sim_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("cosine_similarity_clamped verification clean");
    end else begin
      $display("cosine_similarity_clamped verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/csc_pkg.sv
hdl/csc_if.sv
hdl/cosine_similarity_clamped.sv
dv/cosine_similarity_clamped_test.sv
